// ----- rtl/tgp_pkg.sv -----
package tgp_pkg;

    // default sizes
    localparam int unsigned PC_SHIFT_DEF            = 3;
    localparam int unsigned GLOBAL_HISTORY_BITS_DEF = 15;
    localparam int unsigned LOCAL_HISTORY_BITS_DEF  = 10;
    localparam int unsigned LOCAL_TABLE_ENTRIES_DEF = 4096;
    localparam int unsigned CHOOSER_ENTRIES_DEF     = 2048;
    localparam int unsigned CHOOSER_DEPTH_DEF       = 4;

    // width of the pc slice that is bit-reversed into the gshare index
    localparam int unsigned REV_BITS = 12;
    // widest chooser record the scan function takes
    localparam int unsigned REC_MAX_W = 16;
    localparam int unsigned REC_MAX_PAIRS = REC_MAX_W / 2;

    // two-bit counter values
    localparam logic [1:0] CNT_WEAK_NT = 2'b01;
    localparam logic [1:0] CNT_MAX     = 2'b11;
    localparam logic [1:0] CNT_MIN     = 2'b00;

    // chooser pair codes: {gshare correct, pag correct}
    localparam logic [1:0] PAIR_PAG_ONLY    = 2'b01;
    localparam logic [1:0] PAIR_GSHARE_ONLY = 2'b10;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PAG_RD,
        ST_UPDATE
    } tgp_state_t;

    // mirror of the low pc slice: bit i moves to bit REV_BITS-1-i
    function automatic logic [REV_BITS-1:0] reverse_bits(input logic [REV_BITS-1:0] v);
        logic [REV_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < REV_BITS; i++)
        begin
            r[REV_BITS-1-i] = v[i];
        end
        return r;
    endfunction

    // saturating two-bit counter step
    function automatic logic [1:0] train(input logic [1:0] c, input logic t);
        logic [1:0] n;
        n = c;
        if (t)
        begin
            if (c != CNT_MAX)
                n = c + 2'd1;
        end
        else
        begin
            if (c != CNT_MIN)
                n = c - 2'd1;
        end
        return n;
    endfunction

    // newest pair with a sole winner decides, gshare when none
    function automatic logic chooser_pick(input logic [REC_MAX_W-1:0] rec,
                                          input int unsigned depth);
        logic       found;
        logic       pick;
        logic [1:0] pair;
        found = 1'b0;
        pick  = 1'b0;
        for (int k = 0; k < REC_MAX_PAIRS; k++)
        begin
            pair = rec[2*k +: 2];
            if (!found && (k < depth))
            begin
                if (pair == PAIR_PAG_ONLY)
                begin
                    pick  = 1'b1;
                    found = 1'b1;
                end
                else if (pair == PAIR_GSHARE_ONLY)
                begin
                    found = 1'b1;
                end
            end
        end
        return pick;
    endfunction

endpackage

// ----- rtl/tgp_ram.sv -----
module tgp_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tournament_gshare_pag_predictor.sv -----
// channel   dir  signals                                          transfer
// command   in   start, busy, branch_pc, taken                    start && !busy
// result    out  done, predicted_taken, gshare_taken, pag_taken,  every cycle done is high
//                chose_pag, mispredicted
//
// one branch at a time, busy until write-back: the local history read must finish
// before the shared pag counter table can be read, then all tables are written back.
// the result strobe is registered from the update state, which follows the pag
// read state, and holds for one cycle.
// after reset a clearing pass writes every table entry, one per cycle, until the
// deepest table is done (gshare, 32768 entries, by default); busy is high.
// receiver cannot stall; table sizes must be powers of two, not checked by the block.
module tournament_gshare_pag_predictor #(
    parameter int unsigned PC_SHIFT            = tgp_pkg::PC_SHIFT_DEF,
    parameter int unsigned GLOBAL_HISTORY_BITS = tgp_pkg::GLOBAL_HISTORY_BITS_DEF,
    parameter int unsigned LOCAL_HISTORY_BITS  = tgp_pkg::LOCAL_HISTORY_BITS_DEF,
    parameter int unsigned LOCAL_TABLE_ENTRIES = tgp_pkg::LOCAL_TABLE_ENTRIES_DEF,
    parameter int unsigned CHOOSER_ENTRIES     = tgp_pkg::CHOOSER_ENTRIES_DEF,
    parameter int unsigned CHOOSER_DEPTH       = tgp_pkg::CHOOSER_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] branch_pc,
    input  logic        taken,
    output logic        done,
    output logic        predicted_taken,
    output logic        gshare_taken,
    output logic        pag_taken,
    output logic        chose_pag,
    output logic        mispredicted
);

    import tgp_pkg::*;

    localparam int unsigned GS_DEPTH  = 1 << GLOBAL_HISTORY_BITS;
    localparam int unsigned PAG_DEPTH = 1 << LOCAL_HISTORY_BITS;
    localparam int unsigned GS_AW     = GLOBAL_HISTORY_BITS;
    localparam int unsigned PAG_AW    = LOCAL_HISTORY_BITS;
    localparam int unsigned LH_AW     = $clog2(LOCAL_TABLE_ENTRIES);
    localparam int unsigned CH_AW     = $clog2(CHOOSER_ENTRIES);
    localparam int unsigned REC_W     = 2 * CHOOSER_DEPTH;
    localparam int unsigned MAX_A     = (GS_DEPTH > PAG_DEPTH) ? GS_DEPTH : PAG_DEPTH;
    localparam int unsigned MAX_B     = (LOCAL_TABLE_ENTRIES > CHOOSER_ENTRIES) ?
                                        LOCAL_TABLE_ENTRIES : CHOOSER_ENTRIES;
    localparam int unsigned CLEAR_DEPTH = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int unsigned CLR_W       = $clog2(CLEAR_DEPTH);

    tgp_state_t state_reg, state_next;

    logic [GS_AW-1:0]  ghist_reg, ghist_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic [GS_AW-1:0]  gidx_reg;
    logic [LH_AW-1:0]  lidx_reg;
    logic [CH_AW-1:0]  cidx_reg;
    logic              taken_reg;
    logic              done_reg, done_next;
    logic              pred_reg, gs_reg, pag_reg, chose_reg, mis_reg;

    logic              accept;
    logic [31:0]       word;
    logic [GS_AW-1:0]  gidx;
    logic [LH_AW-1:0]  lidx;
    logic [CH_AW-1:0]  cidx;
    logic              clear_last;

    // memory ports
    logic              rd_first, rd_pag;
    logic              gs_we, lh_we, pag_we, ch_we;
    logic [GS_AW-1:0]  gs_waddr;
    logic [LH_AW-1:0]  lh_waddr;
    logic [PAG_AW-1:0] pag_waddr;
    logic [CH_AW-1:0]  ch_waddr;
    logic [1:0]        gs_wdata, pag_wdata;
    logic [LOCAL_HISTORY_BITS-1:0] lh_wdata, lh_rdata;
    logic [REC_W-1:0]  ch_wdata, ch_rdata;
    logic [1:0]        gs_rdata, pag_rdata;

    // prediction and training values
    logic              g_pred, p_pred, use_pag, pred;
    logic [1:0]        pair_bits;
    logic [REC_W+1:0]  rec_shift;

    // index generation from the command ports
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign word   = branch_pc >> PC_SHIFT;
    assign gidx   = GS_AW'(reverse_bits(word[REV_BITS-1:0])) ^ ghist_reg;
    assign lidx   = word[LH_AW-1:0];
    assign cidx   = word[CH_AW-1:0];
    assign clear_last = (clr_reg == CLR_W'(CLEAR_DEPTH - 1));

    // prediction from the read data
    assign g_pred    = gs_rdata[1];
    assign p_pred    = pag_rdata[1];
    assign use_pag   = chooser_pick(REC_MAX_W'(ch_rdata), CHOOSER_DEPTH);
    assign pred      = use_pag ? p_pred : g_pred;
    assign pair_bits = {g_pred == taken_reg, p_pred == taken_reg};
    assign rec_shift = {ch_rdata, pair_bits};

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ghist_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ghist_reg <= ghist_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // captured command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gidx_reg  <= gidx;
            lidx_reg  <= lidx;
            cidx_reg  <= cidx;
            taken_reg <= taken;
        end
        if (state_reg == ST_UPDATE)
        begin
            pred_reg  <= pred;
            gs_reg    <= g_pred;
            pag_reg   <= p_pred;
            chose_reg <= use_pag;
            mis_reg   <= pred != taken_reg;
        end
    end

    // sequencer: clearing pass, reads, write-back
    always_comb
    begin
        state_next = state_reg;
        ghist_next = ghist_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        rd_first   = 1'b0;
        rd_pag     = 1'b0;
        gs_we      = 1'b0;
        lh_we      = 1'b0;
        pag_we     = 1'b0;
        ch_we      = 1'b0;
        gs_waddr   = gidx_reg;
        lh_waddr   = lidx_reg;
        pag_waddr  = lh_rdata;
        ch_waddr   = cidx_reg;
        gs_wdata   = train(gs_rdata, taken_reg);
        pag_wdata  = train(pag_rdata, taken_reg);
        lh_wdata   = {lh_rdata[LOCAL_HISTORY_BITS-2:0], taken_reg};
        ch_wdata   = rec_shift[REC_W-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                gs_we     = ({1'b0, clr_reg} < (CLR_W+1)'(GS_DEPTH));
                lh_we     = ({1'b0, clr_reg} < (CLR_W+1)'(LOCAL_TABLE_ENTRIES));
                pag_we    = ({1'b0, clr_reg} < (CLR_W+1)'(PAG_DEPTH));
                ch_we     = ({1'b0, clr_reg} < (CLR_W+1)'(CHOOSER_ENTRIES));
                gs_waddr  = clr_reg[GS_AW-1:0];
                lh_waddr  = clr_reg[LH_AW-1:0];
                pag_waddr = clr_reg[PAG_AW-1:0];
                ch_waddr  = clr_reg[CH_AW-1:0];
                gs_wdata  = CNT_WEAK_NT;
                pag_wdata = CNT_WEAK_NT;
                lh_wdata  = '0;
                ch_wdata  = '0;
                clr_next  = clr_reg + CLR_W'(1);
                if (clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    rd_first   = 1'b1;
                    state_next = ST_PAG_RD;
                end
            end
            ST_PAG_RD:
            begin
                rd_pag     = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                gs_we      = 1'b1;
                lh_we      = 1'b1;
                pag_we     = 1'b1;
                ch_we      = 1'b1;
                ghist_next = {ghist_reg[GS_AW-2:0], taken_reg};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // table memories
    tgp_ram #(.DEPTH(GS_DEPTH), .WIDTH(2)) u_gshare (
        .clk   (clk),
        .we    (gs_we),
        .waddr (gs_waddr),
        .wdata (gs_wdata),
        .re    (rd_first),
        .raddr (gidx),
        .rdata (gs_rdata)
    );

    tgp_ram #(.DEPTH(LOCAL_TABLE_ENTRIES), .WIDTH(LOCAL_HISTORY_BITS)) u_local (
        .clk   (clk),
        .we    (lh_we),
        .waddr (lh_waddr),
        .wdata (lh_wdata),
        .re    (rd_first),
        .raddr (lidx),
        .rdata (lh_rdata)
    );

    tgp_ram #(.DEPTH(PAG_DEPTH), .WIDTH(2)) u_pag (
        .clk   (clk),
        .we    (pag_we),
        .waddr (pag_waddr),
        .wdata (pag_wdata),
        .re    (rd_pag),
        .raddr (lh_rdata),
        .rdata (pag_rdata)
    );

    tgp_ram #(.DEPTH(CHOOSER_ENTRIES), .WIDTH(REC_W)) u_chooser (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .re    (rd_first),
        .raddr (cidx),
        .rdata (ch_rdata)
    );

    // result ports
    assign done            = done_reg;
    assign predicted_taken = pred_reg;
    assign gshare_taken    = gs_reg;
    assign pag_taken       = pag_reg;
    assign chose_pag       = chose_reg;
    assign mispredicted    = mis_reg;

    // every transfer gives its result after the pag read and update states
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("result missing after transfer");

    // no result without a transfer ahead of the pag read and update states
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without transfer");

    // a result strobe lasts a single cycle
    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    // the write-back step raises the result strobe and leaves the block idle
    a_writeback_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> done && !busy)
        else $error("write-back did not complete the item");

endmodule
